/* rtl/smbus_temp_word_check_convert_assert.svh */
// Assertion macros used by the checker file of the SMBus word check block.
`ifndef SMBUS_TEMP_WORD_CHECK_CONVERT_ASSERT_SVH
`define SMBUS_TEMP_WORD_CHECK_CONVERT_ASSERT_SVH

// Concurrent check on the rising clock, off while reset is low.
`define STC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stc: concurrent check failed");

// Same check with a caller supplied message.
`define STC_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

/* rtl/stc_pkg.sv */
// Package: constants and types of the SMBus word check and convert block.
`timescale 1ns / 1ps
package stc_pkg;

  localparam int unsigned AddrWidth = 7;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned TempWidth = 17;

  localparam logic [AddrWidth-1:0] AddrReset        = 7'd90;
  localparam logic [ByteWidth-1:0] CrcPoly          = 8'h07;
  localparam logic [TempWidth-1:0] KelvinOffsetCenti = 17'd27315;
  localparam int unsigned          ErrorFlagBit     = 15;

  // Result status of one word
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUS     = 2'd1,
    STATUS_PEC     = 2'd2,
    STATUS_DEV_ERR = 2'd3
  } status_e;

endpackage

/* rtl/smbus_temp_word_check_convert.sv */
// A word accepted at an edge is loaded into the first of three register stages
// and shows on the output once it reaches the third.
// Throughput: one word per cycle; a stall on the output holds all three stages.
// Stages: CRC of write address and command, CRC of read address and low byte
// plus temperature, CRC of high byte with the checks into the output register.
// Reset clears all valid bits and loads slave address 90.
`timescale 1ns / 1ps
module smbus_temp_word_check_convert (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic [stc_pkg::AddrWidth-1:0]       cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [stc_pkg::ByteWidth-1:0]       command_byte_i,
  input  logic [stc_pkg::ByteWidth-1:0]       data_low_i,
  input  logic [stc_pkg::ByteWidth-1:0]       data_high_i,
  input  logic [stc_pkg::ByteWidth-1:0]       received_pec_i,
  input  logic                                bus_failed_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_code_o,
  output logic [stc_pkg::WordWidth-1:0]       raw_word_o,
  output logic [stc_pkg::ByteWidth-1:0]       computed_pec_o,
  output logic signed [stc_pkg::TempWidth-1:0] temperature_centi_o
);
  import stc_pkg::*;

  logic                 advance;
  logic [AddrWidth-1:0] slave_addr_q;

  // stage 1
  logic                 s1_valid_q;
  logic [AddrWidth-1:0] s1_addr_q;
  logic [ByteWidth-1:0] s1_crc_q, s1_lo_q, s1_hi_q, s1_pec_q;
  logic                 s1_fail_q;
  logic [ByteWidth-1:0] crc_aw, crc_cmd;

  // stage 2
  logic                 s2_valid_q;
  logic [ByteWidth-1:0] s2_crc_q, s2_pec_q;
  logic [WordWidth-1:0] s2_word_q;
  logic [TempWidth-1:0] s2_temp_q;
  logic                 s2_fail_q;
  logic [ByteWidth-1:0] crc_ar, crc_lo;
  logic [TempWidth-1:0] temp_d;

  // stage 3 / output
  logic                 s3_valid_q;
  status_e              s3_status_q, s3_status_d;
  logic [WordWidth-1:0] s3_raw_q, s3_raw_d;
  logic [ByteWidth-1:0] s3_cpec_q, s3_cpec_d;
  logic [TempWidth-1:0] s3_temp_q, s3_temp_d;
  logic [ByteWidth-1:0] crc_hi;

  // whole pipe moves when the output slot is free or being taken
  assign advance    = !s3_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // slave address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= AddrReset;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  // stage 1: write address, then command
  stc_crc_byte u_crc_aw (
    .crc_i  ('0),
    .data_i ({slave_addr_q, 1'b0}),
    .crc_o  (crc_aw)
  );
  stc_crc_byte u_crc_cmd (
    .crc_i  (crc_aw),
    .data_i (command_byte_i),
    .crc_o  (crc_cmd)
  );

  // stage 2: read address, then low byte
  stc_crc_byte u_crc_ar (
    .crc_i  (s1_crc_q),
    .data_i ({s1_addr_q, 1'b1}),
    .crc_o  (crc_ar)
  );
  stc_crc_byte u_crc_lo (
    .crc_i  (crc_ar),
    .data_i (s1_lo_q),
    .crc_o  (crc_lo)
  );
  // temperature = 2*word - 27315, wraps to 17 bits
  assign temp_d = {s1_hi_q, s1_lo_q, 1'b0} - KelvinOffsetCenti;

  // stage 3: high byte, then the checks in priority order
  stc_crc_byte u_crc_hi (
    .crc_i  (s2_crc_q),
    .data_i (s2_word_q[WordWidth-1 -: ByteWidth]),
    .crc_o  (crc_hi)
  );

  always_comb begin
    s3_status_d = STATUS_OK;
    s3_raw_d    = '0;
    s3_cpec_d   = '0;
    s3_temp_d   = '0;
    if (s2_fail_q) begin
      s3_status_d = STATUS_BUS;
    end else if (crc_hi != s2_pec_q) begin
      s3_status_d = STATUS_PEC;
      s3_cpec_d   = crc_hi;
    end else if (s2_word_q[ErrorFlagBit]) begin
      s3_status_d = STATUS_DEV_ERR;
      s3_raw_d    = s2_word_q;
      s3_cpec_d   = crc_hi;
    end else begin
      s3_raw_d    = s2_word_q;
      s3_cpec_d   = crc_hi;
      s3_temp_d   = s2_temp_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_addr_q   <= slave_addr_q;
      s1_crc_q    <= crc_cmd;
      s1_lo_q     <= data_low_i;
      s1_hi_q     <= data_high_i;
      s1_pec_q    <= received_pec_i;
      s1_fail_q   <= bus_failed_i;

      s2_crc_q    <= crc_lo;
      s2_pec_q    <= s1_pec_q;
      s2_word_q   <= {s1_hi_q, s1_lo_q};
      s2_temp_q   <= temp_d;
      s2_fail_q   <= s1_fail_q;

      s3_status_q <= s3_status_d;
      s3_raw_q    <= s3_raw_d;
      s3_cpec_q   <= s3_cpec_d;
      s3_temp_q   <= s3_temp_d;
    end
  end

  assign out_valid_o         = s3_valid_q;
  assign status_code_o       = s3_status_q;
  assign raw_word_o          = s3_raw_q;
  assign computed_pec_o      = s3_cpec_q;
  assign temperature_centi_o = $signed(s3_temp_q);

endmodule

/* rtl/stc_crc_byte.sv */
// One byte of the SMBus CRC-8 (poly 0x07, MSB first), combinational.
`timescale 1ns / 1ps
module stc_crc_byte (
  input  logic [stc_pkg::ByteWidth-1:0] crc_i,
  input  logic [stc_pkg::ByteWidth-1:0] data_i,
  output logic [stc_pkg::ByteWidth-1:0] crc_o
);
  import stc_pkg::*;

  // Eight shift steps, xor poly when the top bit falls out
  always_comb begin
    logic [ByteWidth-1:0] c;
    c = crc_i ^ data_i;
    for (int b = 0; b < ByteWidth; b++) begin
      if (c[ByteWidth-1]) begin
        c = {c[ByteWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteWidth-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/stc_checker.sv */
// Port level checker for the SMBus word check block, bound to the top level.
`timescale 1ns / 1ps
`include "smbus_temp_word_check_convert_assert.svh"
module stc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [1:0]                           status_code_o,
  input logic [stc_pkg::WordWidth-1:0]        raw_word_o,
  input logic [stc_pkg::ByteWidth-1:0]        computed_pec_o,
  input logic signed [stc_pkg::TempWidth-1:0] temperature_centi_o
);
  import stc_pkg::*;

  logic [TempWidth-1:0] temp_expect;
  assign temp_expect = {raw_word_o, 1'b0} - KelvinOffsetCenti;

  // a shown word stays until taken
  `STC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // bus failure reports nothing else
  `STC_ASSERT_MSG(a_bus_zero, clk_i, rst_ni,
    out_valid_o && status_code_o == STATUS_BUS |->
      raw_word_o == '0 && computed_pec_o == '0 && temperature_centi_o == '0,
    "stc: bus failure word carries data")

  // PEC mismatch hides the word
  `STC_ASSERT(a_pec_zero, clk_i, rst_ni,
    out_valid_o && status_code_o == STATUS_PEC |->
      raw_word_o == '0 && temperature_centi_o == '0)

  // device error: flag set, no temperature
  `STC_ASSERT(a_dev_err, clk_i, rst_ni,
    out_valid_o && status_code_o == STATUS_DEV_ERR |->
      raw_word_o[ErrorFlagBit] && temperature_centi_o == '0)

  // good word: flag clear and temperature follows the word
  `STC_ASSERT_MSG(a_ok_temp, clk_i, rst_ni,
    out_valid_o && status_code_o == STATUS_OK |->
      !raw_word_o[ErrorFlagBit] && $unsigned(temperature_centi_o) == temp_expect,
    "stc: temperature does not match word")

endmodule

bind smbus_temp_word_check_convert stc_checker u_stc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_code_o       (status_code_o),
  .raw_word_o          (raw_word_o),
  .computed_pec_o      (computed_pec_o),
  .temperature_centi_o (temperature_centi_o)
);
